@@ rtl/hrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'd1;

  localparam logic [7:0] SATURATION_RST = 8'd255;
  localparam logic [7:0] BRIGHTNESS_RST = 8'd255;

  // 60 degrees in hue units
  localparam logic [15:0] SECTOR_SPAN = 16'd7680;
  // floor(n * RECIP15 / 2^18) == floor(n / 15) for n < 3840
  localparam logic [14:0] RECIP15 = 15'd17477;
  // floor(p * RECIP255 / 2^23) == floor(p / 255) for p < 65536
  localparam logic [16:0] RECIP255 = 17'd32897;

  localparam logic [3:0] SEC_0 = 4'd0;
  localparam logic [3:0] SEC_1 = 4'd1;
  localparam logic [3:0] SEC_2 = 4'd2;
  localparam logic [3:0] SEC_3 = 4'd3;
  localparam logic [3:0] SEC_4 = 4'd4;
  localparam logic [3:0] SEC_MAX = 4'd8;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] m;
  } hrc_chroma_t;

endpackage
`default_nettype wire

@@ rtl/hrc_chroma.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrc_chroma
// Chroma c = round(v*s/255) and offset m = v - c from the configuration,
// two register stages, updated every cycle.
// ----------------------------------------------------------------------------
module hrc_chroma (
  input  wire logic               clk,
  input  wire logic [7:0]         saturation,
  input  wire logic [7:0]         brightness,
  output hrc_pkg::hrc_chroma_t    chroma
);

  logic [15:0]          prod_r;
  logic [7:0]           bright_r;
  logic [31:0]          c_prod;
  logic [7:0]           c_nxt;
  hrc_pkg::hrc_chroma_t chroma_r;

  assign c_prod = 32'(prod_r) * 32'(hrc_pkg::RECIP255);
  assign c_nxt  = c_prod[30:23];

  always_ff @(posedge clk) begin
    prod_r     <= 16'(brightness) * 16'(saturation) + 16'd127;
    bright_r   <= brightness;
    chroma_r.c <= c_nxt;
    chroma_r.m <= bright_r - c_nxt;
  end

  assign chroma = chroma_r;

endmodule
`default_nettype wire

@@ rtl/hsv_to_rgb_converter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Hue to RGB conversion at the configured saturation and brightness.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while out_stall is low; five register stages with per-stage valid.
// Chroma follows a configuration write through the configuration register and the two hrc_chroma stages.
// Reset: saturation and brightness return to 255, all stage valids clear.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [hrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [15:0]                       in_hue,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_red,
  output logic [7:0]                             out_green,
  output logic [7:0]                             out_blue
);

  logic [7:0] saturation_r;
  logic [7:0] brightness_r;
  hrc_pkg::hrc_chroma_t chroma;

  logic [5:1] vld_r;
  logic [5:1] rdy;

  logic [15:0] hue1_r;
  logic [3:0]  sec1_r;
  logic [12:0] rem2_r;
  logic [3:0]  sec2_r;
  logic [7:0]  frac3_r;
  logic [3:0]  sec3_r;
  logic [16:0] xprod4_r;
  logic [3:0]  sec4_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;

  logic [21:0] sec_prod;
  logic [3:0]  sec_nxt;
  logic [15:0] span_off;
  logic [15:0] rem_full;
  logic [26:0] frac_prod;
  logic [8:0]  frac_term;
  logic [7:0]  x_val;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saturation_r <= hrc_pkg::SATURATION_RST;
      brightness_r <= hrc_pkg::BRIGHTNESS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hrc_pkg::CFG_SATURATION: saturation_r <= cfg_data[7:0];
        hrc_pkg::CFG_BRIGHTNESS: brightness_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  hrc_chroma u_chroma (
    .clk        (clk),
    .saturation (saturation_r),
    .brightness (brightness_r),
    .chroma     (chroma)
  );

  // stage handshake: a stage loads when empty or when it drains this cycle
  assign rdy[5] = !vld_r[5] || !out_stall;
  assign rdy[4] = !vld_r[4] || rdy[5];
  assign rdy[3] = !vld_r[3] || rdy[4];
  assign rdy[2] = !vld_r[2] || rdy[3];
  assign rdy[1] = !vld_r[1] || rdy[2];

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_valid;
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
      if (rdy[4]) vld_r[4] <= vld_r[3];
      if (rdy[5]) vld_r[5] <= vld_r[4];
    end
  end

  // stage 1: sector = hue / 7680 = (hue >> 9) / 15
  assign sec_prod = 22'(in_hue[15:9]) * 22'(hrc_pkg::RECIP15);
  assign sec_nxt  = sec_prod[21:18];

  // stage 2: remainder within the sector
  assign span_off = 16'(sec1_r) * hrc_pkg::SECTOR_SPAN;
  assign rem_full = hue1_r - span_off;

  // stage 3: fraction = rem / 30 = (rem >> 1) / 15
  assign frac_prod = 27'(rem2_r[12:1]) * 27'(hrc_pkg::RECIP15);

  // stage 4: secondary product, rising or falling by sector parity
  assign frac_term = sec3_r[0] ? (9'd256 - {1'b0, frac3_r}) : {1'b0, frac3_r};

  // stage 5: placement and offset
  assign x_val = xprod4_r[15:8];

  always_comb begin
    unique case (sec4_r)
      hrc_pkg::SEC_0: begin
        red_nxt = chroma.c; green_nxt = x_val;    blue_nxt = 8'd0;
      end
      hrc_pkg::SEC_1: begin
        red_nxt = x_val;    green_nxt = chroma.c; blue_nxt = 8'd0;
      end
      hrc_pkg::SEC_2: begin
        red_nxt = 8'd0;     green_nxt = chroma.c; blue_nxt = x_val;
      end
      hrc_pkg::SEC_3: begin
        red_nxt = 8'd0;     green_nxt = x_val;    blue_nxt = chroma.c;
      end
      hrc_pkg::SEC_4: begin
        red_nxt = x_val;    green_nxt = 8'd0;     blue_nxt = chroma.c;
      end
      default: begin
        red_nxt = chroma.c; green_nxt = 8'd0;     blue_nxt = x_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hue1_r <= in_hue;
      sec1_r <= sec_nxt;
    end
    if (rdy[2]) begin
      rem2_r <= rem_full[12:0];
      sec2_r <= sec1_r;
    end
    if (rdy[3]) begin
      frac3_r <= frac_prod[25:18];
      sec3_r  <= sec2_r;
    end
    if (rdy[4]) begin
      xprod4_r <= 17'(chroma.c) * 17'(frac_term) + 17'd128;
      sec4_r   <= sec3_r;
    end
    if (rdy[5]) begin
      red_r   <= red_nxt + chroma.m;
      green_r <= green_nxt + chroma.m;
      blue_r  <= blue_nxt + chroma.m;
    end
  end

  assign out_valid = vld_r[5];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a stage is empty");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (sec1_r <= hrc_pkg::SEC_MAX))
    else $error("sector out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (rem2_r < hrc_pkg::SECTOR_SPAN[12:0]))
    else $error("sector remainder out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !rdy[4]) |=> ($stable(xprod4_r) && $stable(sec4_r)))
    else $error("stalled stage changed");
`endif

endmodule
`default_nettype wire
